/* rtl/bitmap_chunk_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Bitmap chunk allocator assertion macros
// Shared concurrent assertion forms for the allocator checks.
// ----------------------------------------------------------------------------
`ifndef BITMAP_CHUNK_ALLOCATOR_MACROS_SVH
`define BITMAP_CHUNK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BCA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bca_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap chunk allocator package
// Shared types, codes and defaults of the allocator.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int DEF_NUM_CHUNKS  = 32;
  localparam int DEF_CHUNK_BYTES = 64;

  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_EN  = 2'd1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_DISABLED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_ADDR  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DIV,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic finish;
    logic push;
  } bca_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } bca_stat_t;

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* rtl/bca_ctrl.sv */
// ----------------------------------------------------------------------------
// Bitmap chunk allocator controller
// Sequences request intake, the chunk index lookup and result hand-off.
// ----------------------------------------------------------------------------
module bca_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bca_pkg::bca_stat_t  stat,
  output bca_pkg::bca_cmd_t   cmd
);

  bca_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bca_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      bca_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = stat.need_div ? bca_pkg::CS_DIV : bca_pkg::CS_DONE;
        end
      end
      bca_pkg::CS_DIV: begin
        cmd.finish = 1'b1;
        state_nxt  = bca_pkg::CS_DONE;
      end
      bca_pkg::CS_DONE: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = bca_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = bca_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bca_dp.sv */
// ----------------------------------------------------------------------------
// Bitmap chunk allocator datapath
// Bitmap, configuration registers, range check, chunk index compare and
// result regs.
// ----------------------------------------------------------------------------
module bca_dp #(
  parameter int NUM_CHUNKS  = bca_pkg::DEF_NUM_CHUNKS,
  parameter int CHUNK_BYTES = bca_pkg::DEF_CHUNK_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bca_pkg::bca_cmd_t                cmd,
  output bca_pkg::bca_stat_t               stat,
  input  logic                             in_operation,
  input  logic [bca_pkg::ADDR_W-1:0]       in_free_address,
  input  logic                             cfg_valid,
  input  logic [bca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bca_pkg::ADDR_W-1:0]       cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [bca_pkg::ADDR_W-1:0]       out_chunk_address
);

  localparam int IDX_W      = bca_pkg::idx_width(NUM_CHUNKS);
  localparam int HEAP_BYTES = NUM_CHUNKS * CHUNK_BYTES;
  localparam int OFF_W      = $clog2(HEAP_BYTES) + 1;
  localparam logic [bca_pkg::ADDR_W-1:0] HEAP_SIZE = bca_pkg::ADDR_W'(HEAP_BYTES);
  localparam logic [bca_pkg::ADDR_W-1:0] CHUNK_SIZE = bca_pkg::ADDR_W'(CHUNK_BYTES);

  logic [bca_pkg::ADDR_W-1:0] heap_base_r;
  logic                       alloc_en_r;
  logic [NUM_CHUNKS-1:0]      bm_r, bm_nxt;

  logic [OFF_W-1:0]           off_r;
  logic [NUM_CHUNKS:0]        thr_ge;
  logic [IDX_W-1:0]           free_idx;

  bca_pkg::status_t           res_status_r, res_status_nxt;
  logic [bca_pkg::ADDR_W-1:0] res_addr_r, res_addr_nxt;

  logic                       out_valid_r;
  bca_pkg::status_t           out_status_r;
  logic [bca_pkg::ADDR_W-1:0] out_addr_r;

  logic [bca_pkg::ADDR_W:0]   offset_full;
  logic                       in_range;
  logic                       is_free;
  logic                       full;
  logic                       alloc_hit;
  logic [IDX_W-1:0]           alloc_idx;
  logic [bca_pkg::ADDR_W-1:0] alloc_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      alloc_en_r  <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == bca_pkg::REG_HEAP_BASE) begin
        heap_base_r <= cfg_data;
      end else if (cfg_index == bca_pkg::REG_ALLOC_EN) begin
        alloc_en_r <= cfg_data[0];
      end
    end
  end

  assign offset_full = {1'b0, in_free_address} - {1'b0, heap_base_r};
  assign in_range    = !offset_full[bca_pkg::ADDR_W] &&
                       (offset_full[bca_pkg::ADDR_W-1:0] < HEAP_SIZE);
  assign is_free     = (in_operation == bca_pkg::OP_FREE);

  always_comb begin
    alloc_idx = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (!bm_r[i]) alloc_idx = IDX_W'(i);
    end
  end

  assign full       = &bm_r;
  assign alloc_hit  = !is_free && alloc_en_r && !full;
  assign alloc_addr = heap_base_r + bca_pkg::ADDR_W'(alloc_idx) * CHUNK_SIZE;

  assign stat.need_div = is_free && (heap_base_r != '0) && in_range;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      off_r <= OFF_W'(offset_full[bca_pkg::ADDR_W-1:0]);
    end
  end

  always_comb begin
    thr_ge = '0;
    for (int k = 0; k < NUM_CHUNKS; k++) begin
      thr_ge[k] = (off_r >= OFF_W'(k * CHUNK_BYTES));
    end
  end

  always_comb begin
    free_idx = '0;
    for (int k = 0; k < NUM_CHUNKS; k++) begin
      if (thr_ge[k] && !thr_ge[k + 1]) free_idx = free_idx | IDX_W'(k);
    end
  end

  always_comb begin
    bm_nxt = bm_r;
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      if (cmd.start && alloc_hit && (alloc_idx == IDX_W'(i))) bm_nxt[i] = 1'b1;
      if (cmd.finish && (free_idx == IDX_W'(i))) bm_nxt[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_r <= '0;
    end else begin
      bm_r <= bm_nxt;
    end
  end

  always_comb begin
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    if (cmd.finish) begin
      res_status_nxt = bca_pkg::ST_FREED;
      res_addr_nxt   = '0;
    end else if (cmd.start) begin
      res_addr_nxt = '0;
      if (is_free) begin
        res_status_nxt = bca_pkg::ST_BAD_ADDR;
      end else if (!alloc_en_r) begin
        res_status_nxt = bca_pkg::ST_DISABLED;
      end else if (full) begin
        res_status_nxt = bca_pkg::ST_FULL;
      end else begin
        res_status_nxt = bca_pkg::ST_ALLOCATED;
        res_addr_nxt   = alloc_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_chunk_address = out_addr_r;

endmodule

/* rtl/bitmap_chunk_allocator.sv */
// ----------------------------------------------------------------------------
// Bitmap chunk allocator
// Allocate and rejected requests: result register loaded at acceptance, then
// copied to the output register in CS_DONE; an in-range free with a nonzero
// heap base first passes CS_DIV for the chunk index compare. Next request
// accepted back in CS_IDLE once the result is loaded; a held result stalls
// the controller. Reset clears the bitmap and configuration registers at once.
// ----------------------------------------------------------------------------
`include "bitmap_chunk_allocator_macros.svh"

module bitmap_chunk_allocator #(
  parameter int NUM_CHUNKS  = bca_pkg::DEF_NUM_CHUNKS,
  parameter int CHUNK_BYTES = bca_pkg::DEF_CHUNK_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [bca_pkg::ADDR_W-1:0]       in_free_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [bca_pkg::ADDR_W-1:0]       out_chunk_address,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bca_pkg::ADDR_W-1:0]       cfg_data
);

  bca_pkg::bca_cmd_t  cmd;
  bca_pkg::bca_stat_t stat;

  assign cfg_ready = 1'b1;

  bca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bca_dp #(
    .NUM_CHUNKS  (NUM_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_free_address   (in_free_address),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_chunk_address (out_chunk_address)
  );

  `BCA_ASSERT_IMPLY(a_addr_zero, clk, rst_n, out_valid && (out_status != 3'(bca_pkg::ST_ALLOCATED)), out_chunk_address == '0, "nonzero address on non-allocate result")
  `BCA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while busy")
  `BCA_ASSERT_IMPLY(a_push_slot_free, clk, rst_n, cmd.push, !out_valid || out_ready, "result overwritten before taken")
  `BCA_ASSERT_IMPLY(a_no_cmd_idle, clk, rst_n, in_ready, !cmd.finish && !cmd.push, "datapath busy while idle")

endmodule

/* dv/tb_bitmap_chunk_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap chunk allocator testbench
// Drives allocate and free requests with random gaps on both handshakes,
// predicts every reply from a local copy of the bitmap and the registers,
// and checks each reply in order. Covers the reset state, heap bounds,
// wrapped heaps, unused register indexes and a long output stall.
// ----------------------------------------------------------------------------
module tb_bitmap_chunk_allocator;
  import bca_pkg::*;

  localparam int NUM_CHUNKS    = DEF_NUM_CHUNKS;
  localparam int CHUNK_BYTES   = DEF_CHUNK_BYTES;
  localparam logic [ADDR_W-1:0] HEAP_SPAN = NUM_CHUNKS * CHUNK_BYTES;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int PHASE_ITEMS   = 160;
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_NS    = 4_000_000;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] chunk_address;
  } alloc_reply_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_operation;
  logic [ADDR_W-1:0]    in_free_address;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_status;
  logic [ADDR_W-1:0]    out_chunk_address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  logic [NUM_CHUNKS-1:0] busy_chunks = '0;
  logic [ADDR_W-1:0]     base_reg    = '0;
  logic                  enable_reg  = 1'b0;
  alloc_reply_t          pending_replies[$];
  int                    mismatch_count = 0;
  logic [ADDR_W-1:0]     heap_setting = '0;
  bit                    no_idle = 1'b0;
  int                    hold_off_cycles = 0;

  bitmap_chunk_allocator #(
    .NUM_CHUNKS (NUM_CHUNKS),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chunk_address(out_chunk_address),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("bitmap_chunk_allocator regression: fail");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic alloc_reply_t allocator_reply(input op_t op, input logic [ADDR_W-1:0] addr);
    alloc_reply_t r;
    logic         found;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  wide;
    int           idx;
    r.status        = ST_BAD_ADDR;
    r.chunk_address = '0;
    if (op == OP_ALLOC) begin
      if (!enable_reg) begin
        r.status = ST_DISABLED;
      end else begin
        r.status = ST_FULL;
        found    = 1'b0;
        for (int i = 0; i < NUM_CHUNKS; i++) begin
          if (!found && !busy_chunks[i]) begin
            found           = 1'b1;
            busy_chunks[i]  = 1'b1;
            wide            = 64'(base_reg) + 64'(i) * 64'(CHUNK_BYTES);
            r.status        = ST_ALLOCATED;
            r.chunk_address = wide[ADDR_W-1:0];
          end
        end
      end
    end else if (base_reg != '0) begin
      lo = 64'(base_reg);
      hi = lo + 64'(NUM_CHUNKS) * 64'(CHUNK_BYTES);
      if (64'(addr) >= lo && 64'(addr) < hi) begin
        idx              = int'((64'(addr) - lo) / 64'(CHUNK_BYTES));
        busy_chunks[idx] = 1'b0;
        r.status         = ST_FREED;
      end
    end
    return r;
  endfunction

  // check reply, then track register writes, then predict the accepted request
  always @(posedge clk) begin : monitor_b
    alloc_reply_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch($sformatf("reply with nothing pending: status=%0d addr=%h",
                                  out_status, out_chunk_address));
        end else begin
          want = pending_replies.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status got %0d want %s", out_status, want.status.name()));
          if (out_chunk_address !== want.chunk_address)
            flag_mismatch($sformatf("chunk_address got %h want %h",
                                    out_chunk_address, want.chunk_address));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEAP_BASE) base_reg = cfg_data;
        else if (cfg_index == REG_ALLOC_EN) enable_reg = cfg_data[0];
      end
      if (in_valid && in_ready)
        pending_replies.push_back(allocator_reply(op_t'(in_operation), in_free_address));
    end
  end

  // receiver: random gap per reply unless streaming, long hold when requested
  initial begin : receiver_b
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (hold_off_cycles != 0) begin
        gap             = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input op_t op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_free_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [ADDR_W-1:0] base, input logic en);
    wait_idle();
    write_register(REG_HEAP_BASE, base);
    write_register(REG_ALLOC_EN, ($urandom() & ~32'h1) | 32'(en));
    heap_setting = base;
  endtask

  function automatic logic [ADDR_W-1:0] pick_free_address();
    logic [ADDR_W-1:0] addr;
    case ($urandom_range(0, 9))
      0:       addr = $urandom();
      1:       addr = heap_setting - 1;
      2:       addr = heap_setting + HEAP_SPAN;
      3:       addr = heap_setting + HEAP_SPAN - 1;
      default: addr = heap_setting + $urandom_range(0, HEAP_SPAN - 1);
    endcase
    return addr;
  endfunction

  task automatic run_traffic(input logic [ADDR_W-1:0] base, input logic en,
                             input int alloc_pct, input bit streaming);
    op_t op;
    configure(base, en);
    no_idle = streaming;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      op = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOC : OP_FREE;
      send_request(op, (op == OP_ALLOC) ? $urandom() : pick_free_address());
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_reset_state();
    send_request(OP_ALLOC, $urandom());
    send_request(OP_FREE, '0);
  endtask

  task automatic test_unset_heap_alloc();
    configure('0, 1'b1);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 32'(CHUNK_BYTES));
  endtask

  task automatic test_free_window();
    configure(32'h0000_1000, 1'b0);
    send_request(OP_FREE, 32'h0000_0fff);
    send_request(OP_FREE, 32'h0000_1000);
    send_request(OP_FREE, 32'h0000_1000 + 32'(2 * CHUNK_BYTES) - 1);
    send_request(OP_FREE, 32'h0000_1000 + HEAP_SPAN - 1);
    send_request(OP_FREE, 32'h0000_1000 + HEAP_SPAN);
    send_request(OP_FREE, 32'hffff_ffff);
    send_request(OP_FREE, 32'h0000_0000);
    send_request(OP_ALLOC, $urandom());
  endtask

  task automatic test_wrapped_heap();
    configure(32'hffff_ffc0, 1'b1);
    send_request(OP_ALLOC, $urandom());
    send_request(OP_ALLOC, $urandom());
    send_request(OP_FREE, 32'hffff_ffff);
    send_request(OP_FREE, 32'h0000_0010);
    send_request(OP_ALLOC, $urandom());
  endtask

  task automatic test_unused_registers();
    wait_idle();
    write_register(REG_SPARE_2, $urandom());
    write_register(REG_SPARE_3, '1);
    send_request(OP_ALLOC, $urandom());
  endtask

  task automatic test_back_pressure();
    configure(32'h0000_2000, 1'b1);
    hold_off_cycles = 300;
    for (int k = 0; k < 16; k++)
      send_request((k % 3 == 2) ? OP_FREE : OP_ALLOC,
                   32'h0000_2000 + $urandom_range(0, HEAP_SPAN - 1));
  endtask

  task automatic test_random_mix();
    run_traffic(32'h0000_1000, 1'b1, 50, 1'b0);
    run_traffic(32'h8000_0000, 1'b1, 90, 1'b0);
    run_traffic($urandom() & ~32'(CHUNK_BYTES - 1), 1'b1, 25, 1'b0);
    run_traffic('0, 1'b1, 60, 1'b0);
    run_traffic(32'hffff_ffff, 1'b1, 50, 1'b0);
    run_traffic($urandom(), 1'b0, 50, 1'b0);
    run_traffic(32'hffff_f800, 1'b1, 70, 1'b0);
  endtask

  task automatic test_streaming();
    run_traffic($urandom() | 32'h1, 1'b1, 55, 1'b1);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= OP_ALLOC;
    in_free_address <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_HEAP_BASE;
    cfg_data        <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_unset_heap_alloc();
    test_free_window();
    test_wrapped_heap();
    test_unused_registers();
    test_back_pressure();
    test_random_mix();
    test_streaming();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("bitmap_chunk_allocator regression: pass");
    end else begin
      $display("bitmap_chunk_allocator regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/bca_pkg.sv
rtl/bca_ctrl.sv
rtl/bca_dp.sv
rtl/bitmap_chunk_allocator.sv
dv/tb_bitmap_chunk_allocator.sv
